>>> hdl/timed_overcurrent_detector_assert.svh
// Assertion macros for the timed overcurrent detector.
// Both expect clk and rst_n in scope and are disabled during reset.
`ifndef TIMED_OVERCURRENT_DETECTOR_ASSERT_SVH
`define TIMED_OVERCURRENT_DETECTOR_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TOD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TOD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tod_pkg.sv
`default_nettype none

package tod_pkg;

    localparam int unsigned NUM_PHASES = 3;
    localparam int unsigned FILT_SUBSTEPS = 4;
    localparam int unsigned SQRT_STEPS = 16;

    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned FILT_W = 48;
    localparam int unsigned LEVEL_W = 16;
    localparam int unsigned CFG_IDX_W = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIP_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_ON_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_OFF_THRESHOLD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_MARGIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_ON_DELTA = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_OFF_DELTA = 3'd7;

    // Filter sub-steps for one phase
    localparam logic [1:0] FSTEP_DIFF = 2'd0;
    localparam logic [1:0] FSTEP_MUL_LO = 2'd1;
    localparam logic [1:0] FSTEP_MUL_HI = 2'd2;
    localparam logic [1:0] FSTEP_UPDATE = 2'd3;

    typedef struct packed {
        logic       capture;
        logic       filt_en;
        logic [1:0] phase;
        logic [1:0] sub;
        logic       sqrt_en;
        logic       sqrt_first;
        logic [3:0] sqrt_k;
        logic       finish;
    } tod_cmd_t;

    typedef struct packed {
        logic out_blocked;
        logic mode_dynamic;
    } tod_status_t;

endpackage

`default_nettype wire

>>> hdl/tod_ctrl.sv
`default_nettype none

module tod_ctrl (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_ready,
    input  tod_pkg::tod_status_t status,
    output tod_pkg::tod_cmd_t  cmd
);
    import tod_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_FILT = 4'b0010,
        ST_SQRT = 4'b0100,
        ST_DONE = 4'b1000
    } tod_state_t;

    tod_state_t state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic [1:0] sub_reg, sub_next;
    logic [3:0] k_reg, k_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            sub_reg <= '0;
            k_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            sub_reg <= sub_next;
            k_reg <= k_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        sub_next = sub_reg;
        k_next = k_reg;
        in_ready = 1'b0;
        cmd = '0;
        cmd.phase = phase_reg;
        cmd.sub = sub_reg;
        cmd.sqrt_k = k_reg;
        cmd.sqrt_first = (k_reg == 4'(SQRT_STEPS - 1));
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    phase_next = '0;
                    sub_next = '0;
                    state_next = ST_FILT;
                end
            end
            ST_FILT:
            begin
                cmd.filt_en = 1'b1;
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'(FILT_SUBSTEPS - 1))
                begin
                    if (phase_reg == 2'(NUM_PHASES - 1))
                    begin
                        k_next = 4'(SQRT_STEPS - 1);
                        state_next = ST_SQRT;
                    end
                    else
                    begin
                        phase_next = phase_reg + 2'd1;
                    end
                end
            end
            ST_SQRT:
            begin
                cmd.sqrt_en = 1'b1;
                k_next = k_reg - 4'd1;
                if (k_reg == 4'd0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!status.out_blocked)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/tod_datapath.sv
`default_nettype none

module tod_datapath (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_we,
    input  wire  [2:0]          cfg_index,
    input  wire  [15:0]         cfg_data,
    input  wire  [31:0]         phase_a_squared,
    input  wire  [31:0]         phase_b_squared,
    input  wire  [31:0]         phase_c_squared,
    input  wire  [15:0]         max_current_out,
    input  tod_pkg::tod_cmd_t   cmd,
    output tod_pkg::tod_status_t status,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic [15:0]         rms_high,
    output logic                trip,
    output logic                alarm
);
    import tod_pkg::*;

    // Configuration registers
    logic [15:0] gain_reg;
    logic [1:0]  mode_reg;
    logic [15:0] trip_thr_reg;
    logic [15:0] on_thr_reg;
    logic [15:0] off_thr_reg;
    logic [15:0] margin_reg;
    logic [15:0] on_delta_reg;
    logic [15:0] off_delta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= '0;
            mode_reg <= '0;
            trip_thr_reg <= '1;
            on_thr_reg <= '1;
            off_thr_reg <= '0;
            margin_reg <= 16'h4000;
            on_delta_reg <= '0;
            off_delta_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FILTER_GAIN:         gain_reg <= cfg_data;
                REG_THRESHOLD_MODE:      mode_reg <= cfg_data[1:0];
                REG_TRIP_THRESHOLD:      trip_thr_reg <= cfg_data;
                REG_ALARM_ON_THRESHOLD:  on_thr_reg <= cfg_data;
                REG_ALARM_OFF_THRESHOLD: off_thr_reg <= cfg_data;
                REG_CURRENT_MARGIN:      margin_reg <= cfg_data;
                REG_ALARM_ON_DELTA:      on_delta_reg <= cfg_data;
                REG_ALARM_OFF_DELTA:     off_delta_reg <= cfg_data;
                default:                 gain_reg <= gain_reg;
            endcase
        end
    end

    // Captured item
    logic [SAMPLE_W-1:0] samp_reg [NUM_PHASES];
    logic [15:0]         maxcur_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            samp_reg[0] <= phase_a_squared;
            samp_reg[1] <= phase_b_squared;
            samp_reg[2] <= phase_c_squared;
            maxcur_reg <= max_current_out;
        end
    end

    // Threshold levels, registered in a chain after capture: margin product, trip, on, off
    logic [31:0]        margin_prod_reg;
    logic [LEVEL_W-1:0] trip_lvl_reg, trip_lvl_next;
    logic [LEVEL_W-1:0] on_lvl_reg, on_lvl_next;
    logic [LEVEL_W-1:0] off_lvl_reg, off_lvl_next;
    logic               dynamic;

    assign dynamic = (mode_reg != 2'd0);

    always_comb
    begin
        if (!dynamic)
        begin
            trip_lvl_next = trip_thr_reg;
            on_lvl_next = on_thr_reg;
            off_lvl_next = off_thr_reg;
        end
        else
        begin
            if (mode_reg[1])
            begin
                trip_lvl_next = (|margin_prod_reg[31:30]) ? '1 : margin_prod_reg[29:14];
            end
            else
            begin
                trip_lvl_next = maxcur_reg;
            end
            on_lvl_next = (trip_lvl_reg > on_delta_reg) ? (trip_lvl_reg - on_delta_reg) : '0;
            off_lvl_next = (on_lvl_reg > off_delta_reg) ? (on_lvl_reg - off_delta_reg) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        margin_prod_reg <= maxcur_reg * margin_reg;
        trip_lvl_reg <= trip_lvl_next;
        on_lvl_reg <= on_lvl_next;
        off_lvl_reg <= off_lvl_next;
    end

    // Low-pass filters, one phase at a time on a shared 16x24 multiplier
    logic [FILT_W-1:0]   filt_reg [NUM_PHASES];
    logic [FILT_W-1:0]   diff_reg;
    logic                neg_reg;
    logic [63:0]         acc_reg;
    logic [31:0]         max_reg;
    logic [SAMPLE_W-1:0] samp_sel;
    logic [FILT_W-1:0]   s_sel;
    logic [FILT_W-1:0]   x_sel;
    logic [FILT_W:0]     up_full;
    logic [FILT_W-1:0]   dn;
    logic [23:0]         mul_b;
    logic [39:0]         mul_p;
    logic [FILT_W-1:0]   s_new;

    assign samp_sel = samp_reg[cmd.phase];
    assign s_sel = filt_reg[cmd.phase];
    assign x_sel = {samp_sel, 16'h0000};
    assign up_full = {1'b0, x_sel} - {1'b0, s_sel};
    assign dn = s_sel - x_sel;
    assign mul_b = (cmd.sub == FSTEP_MUL_LO) ? diff_reg[23:0] : diff_reg[47:24];
    assign mul_p = gain_reg * mul_b;
    assign s_new = neg_reg ? (s_sel - acc_reg[63:16]) : (s_sel + acc_reg[63:16]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PHASES; i++)
            begin
                filt_reg[i] <= '0;
            end
        end
        else if (cmd.filt_en && (cmd.sub == FSTEP_UPDATE))
        begin
            filt_reg[cmd.phase] <= s_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            max_reg <= '0;
        end
        else if (cmd.filt_en)
        begin
            unique case (cmd.sub)
                FSTEP_DIFF:
                begin
                    neg_reg <= up_full[FILT_W];
                    diff_reg <= up_full[FILT_W] ? dn : up_full[FILT_W-1:0];
                end
                FSTEP_MUL_LO:
                begin
                    // Rounding term turns the floor into a ceiling when falling
                    acc_reg <= {24'h0, mul_p} + (neg_reg ? 64'h0000_0000_0000_FFFF : 64'h0);
                end
                FSTEP_MUL_HI:
                begin
                    acc_reg <= acc_reg + {mul_p, 24'h0};
                end
                FSTEP_UPDATE:
                begin
                    if (s_new[47:16] > max_reg)
                    begin
                        max_reg <= s_new[47:16];
                    end
                end
                default:
                begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    // Square root, one result bit per step
    logic [31:0] sq_v_reg;
    logic [31:0] sq_r_reg;
    logic [31:0] v_cur;
    logic [31:0] r_cur;
    logic [31:0] sq_bit;
    logic [31:0] trial;

    assign v_cur = cmd.sqrt_first ? max_reg : sq_v_reg;
    assign r_cur = cmd.sqrt_first ? 32'h0 : sq_r_reg;
    assign sq_bit = 32'h1 << {cmd.sqrt_k, 1'b0};
    assign trial = r_cur + sq_bit;

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_en)
        begin
            if (v_cur >= trial)
            begin
                sq_v_reg <= v_cur - trial;
                sq_r_reg <= (r_cur >> 1) + sq_bit;
            end
            else
            begin
                sq_v_reg <= v_cur;
                sq_r_reg <= r_cur >> 1;
            end
        end
    end

    // Result register and alarm state
    logic [15:0] rms;
    logic        alarm_next;
    logic        out_valid_reg;
    logic        alarm_latched_reg;
    logic [15:0] rms_out_reg;
    logic        trip_out_reg;

    assign rms = sq_r_reg[15:0];

    always_comb
    begin
        priority if (rms >= on_lvl_reg)
        begin
            alarm_next = 1'b1;
        end
        else if (rms <= off_lvl_reg)
        begin
            alarm_next = 1'b0;
        end
        else
        begin
            alarm_next = alarm_latched_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            alarm_latched_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
            alarm_latched_reg <= alarm_next;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rms_out_reg <= rms;
            trip_out_reg <= (rms >= trip_lvl_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign rms_high = rms_out_reg;
    assign trip = trip_out_reg;
    assign alarm = alarm_latched_reg;
    assign status.out_blocked = out_valid_reg && !out_ready;
    assign status.mode_dynamic = dynamic;

endmodule

`default_nettype wire

>>> hdl/timed_overcurrent_detector.sv
// Timed overcurrent detector: three squared phase currents are smoothed by
// first-order low-pass filters, the largest filtered value is reduced to whole
// amps RMS by a floor square root, and the result is compared against a trip
// level and a hysteretic alarm pair (static, or derived from max_current_out).
// Each item runs through the capture that ends with the input transfer,
// twelve filter steps (four per phase on one shared 16x24 multiplier),
// sixteen steps of the bit-serial square root and the finish step, which
// loads the result; the result can leave on the edge after that. The next
// input is taken the cycle after the result is loaded, even while that result
// waits on the output, so the block takes a new item only once it is through
// with the last one; the block stalls only when a second result is ready
// before the first has been taken.
// Configuration writes take effect at once and belong to idle periods.
`default_nettype none

module timed_overcurrent_detector (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_index,
    input  wire  [15:0] cfg_data,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [31:0] phase_a_squared,
    input  wire  [31:0] phase_b_squared,
    input  wire  [31:0] phase_c_squared,
    input  wire  [15:0] max_current_out,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [15:0] rms_high,
    output logic        trip,
    output logic        alarm
);
    import tod_pkg::*;

    tod_cmd_t    dp_cmd;
    tod_status_t dp_status;

    // Sequencer: capture, filter each phase, root, then hand over the result
    tod_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    // Registers, filters, square root, levels and the result register
    tod_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .phase_a_squared (phase_a_squared),
        .phase_b_squared (phase_b_squared),
        .phase_c_squared (phase_c_squared),
        .max_current_out (max_current_out),
        .cmd             (dp_cmd),
        .status          (dp_status),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .rms_high        (rms_high),
        .trip            (trip),
        .alarm           (alarm)
    );

    `include "timed_overcurrent_detector_assert.svh"

    // After an input transfer the block is busy working on it
    `TOD_ASSERT_NEXT(a_busy_after_accept,
                     in_valid && in_ready,
                     !in_ready,
                     "input taken while busy")
    // Dynamic levels keep the alarm set level at or below the trip level
    `TOD_ASSERT_SAME(a_trip_implies_alarm,
                     out_valid && trip && dp_status.mode_dynamic,
                     alarm,
                     "trip without alarm in dynamic mode")
    // A fresh result is always followed by a return to idle
    `TOD_ASSERT_SAME(a_idle_after_result,
                     $rose(out_valid),
                     in_ready,
                     "not idle after result load")

endmodule

`default_nettype wire

>>> tb/timed_overcurrent_detector_tb.sv
`default_nettype none

module timed_overcurrent_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tod_pkg::*;

    // Threshold mode codes as seen on the low two bits of the mode register
    localparam logic [1:0] MODE_STATIC     = 2'd0;
    localparam logic [1:0] MODE_DYNAMIC    = 2'd1;
    localparam logic [1:0] MODE_MARGIN     = 2'd2;
    localparam logic [1:0] MODE_MARGIN_ALT = 2'd3;

    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 150;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [15:0] mc;
    } sample_t;

    typedef struct packed {
        logic [15:0] rms;
        logic        trip;
        logic        alarm;
    } reading_t;

    typedef struct packed {
        logic [15:0] gain;
        logic [15:0] mode_word;
        logic [15:0] trip_lvl;
        logic [15:0] on_lvl;
        logic [15:0] off_lvl;
        logic [15:0] margin;
        logic [15:0] on_delta;
        logic [15:0] off_delta;
    } settings_t;

    // One line of the directed stimulus: optional register set-up, the sample,
    // and a hand-written reading where it is obvious
    typedef struct {
        bit        reconf;
        settings_t cfg;
        sample_t   smp;
        bit        typed;
        reading_t  want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic [31:0] phase_a_squared = '0;
    logic [31:0] phase_b_squared = '0;
    logic [31:0] phase_c_squared = '0;
    logic [15:0] max_current_out = '0;
    logic        out_ready = 1'b0;
    wire         in_ready;
    wire         out_valid;
    wire  [15:0] rms_high;
    wire         trip;
    wire         alarm;

    // Shadow of the block: register copy, filter states and the alarm latch
    settings_t      active;
    logic [47:0]    phase_filter [3] = '{default: '0};
    logic           alarm_state = 1'b0;

    reading_t       expected_readings [$];
    row_t           script [$];
    int             mismatches = 0;
    int             readings_seen = 0;
    int             burst_left = 0;
    int unsigned    op_amp = 0;

    timed_overcurrent_detector dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .phase_a_squared (phase_a_squared),
        .phase_b_squared (phase_b_squared),
        .phase_c_squared (phase_c_squared),
        .max_current_out (max_current_out),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .rms_high        (rms_high),
        .trip            (trip),
        .alarm           (alarm)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hold reset from time zero, release on a rising edge, never assert again
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Hard stop in case a transfer never completes
    initial
    begin
        #10_000_000;
        $display("timed_overcurrent_detector_tb: FAIL");
        $finish;
    end

    function automatic logic [15:0] clamp16(input longint v);
        if (v < 0)
            return 16'h0000;
        if (v > 65535)
            return 16'hFFFF;
        return v[15:0];
    endfunction

    // One low-pass step on a Q32.16 state: add the floored share of the error
    // when rising, take off the rounded-up share when falling
    function automatic logic [47:0] smooth(input logic [47:0] s, input logic [31:0] smp,
                                           input logic [15:0] g);
        logic [63:0] x;
        logic [63:0] d;
        logic [63:0] p;
        x = {16'h0000, smp, 16'h0000};
        if (x >= {16'h0000, s})
        begin
            d = x - {16'h0000, s};
            p = g * d;
            return s + p[63:16];
        end
        else
        begin
            d = {16'h0000, s} - x;
            p = g * d + 64'h0000_0000_0000_FFFF;
            return s - p[63:16];
        end
    endfunction

    // Floor square root, built up one result bit at a time from the top
    function automatic logic [15:0] floor_root(input logic [31:0] v);
        logic [15:0] r;
        logic [15:0] t;
        logic [31:0] sq;
        r = '0;
        for (int k = 15; k >= 0; k--)
        begin
            t = r | (16'd1 << k);
            sq = t * t;
            if (sq <= v)
                r = t;
        end
        return r;
    endfunction

    // Advance the shadow by one sample and return the reading it should give
    function automatic reading_t detector_step(input sample_t s);
        reading_t    r;
        logic [47:0] peak;
        logic [31:0] scaled;
        logic [17:0] trip_raw;
        logic [15:0] trip_l;
        logic [15:0] on_l;
        logic [15:0] off_l;
        logic [1:0]  mode;
        phase_filter[0] = smooth(phase_filter[0], s.a, active.gain);
        phase_filter[1] = smooth(phase_filter[1], s.b, active.gain);
        phase_filter[2] = smooth(phase_filter[2], s.c, active.gain);
        peak = (phase_filter[0] > phase_filter[1]) ? phase_filter[0] : phase_filter[1];
        if (phase_filter[2] > peak)
            peak = phase_filter[2];
        r.rms = floor_root(peak[47:16]);

        mode = active.mode_word[1:0];
        if (mode == MODE_STATIC)
        begin
            trip_l = active.trip_lvl;
            on_l = active.on_lvl;
            off_l = active.off_lvl;
        end
        else
        begin
            if (mode == MODE_MARGIN || mode == MODE_MARGIN_ALT)
            begin
                // Q2.14 margin on the current limit, saturating at full scale
                scaled = s.mc * active.margin;
                trip_raw = scaled[31:14];
                trip_l = (trip_raw > 18'h0FFFF) ? 16'hFFFF : trip_raw[15:0];
            end
            else
                trip_l = s.mc;
            on_l = (trip_l > active.on_delta) ? trip_l - active.on_delta : 16'h0000;
            off_l = (on_l > active.off_delta) ? on_l - active.off_delta : 16'h0000;
        end

        r.trip = (r.rms >= trip_l);
        if (r.rms >= on_l)
            alarm_state = 1'b1;
        else if (r.rms <= off_l)
            alarm_state = 1'b0;
        r.alarm = alarm_state;
        return r;
    endfunction

    function automatic settings_t mk(input logic [15:0] gain, input logic [15:0] mode_word,
                                     input logic [15:0] trip_lvl, input logic [15:0] on_lvl,
                                     input logic [15:0] off_lvl, input logic [15:0] margin,
                                     input logic [15:0] on_delta, input logic [15:0] off_delta);
        settings_t c;
        c.gain = gain;
        c.mode_word = mode_word;
        c.trip_lvl = trip_lvl;
        c.on_lvl = on_lvl;
        c.off_lvl = off_lvl;
        c.margin = margin;
        c.on_delta = on_delta;
        c.off_delta = off_delta;
        return c;
    endfunction

    function automatic void add(input bit reconf, input settings_t c, input logic [31:0] a,
                                input logic [31:0] b, input logic [31:0] cc,
                                input logic [15:0] mc, input bit typed, input reading_t want);
        row_t r;
        r.reconf = reconf;
        r.cfg = c;
        r.smp = {a, b, cc, mc};
        r.typed = typed;
        r.want = want;
        script.push_back(r);
    endfunction

    // Square of an amplitude jittered around the operating point
    function automatic logic [31:0] near_square(input int unsigned centre);
        logic [15:0] v;
        logic [31:0] sq;
        v = clamp16(longint'(centre) + longint'($urandom_range(0, 1200)) - 600);
        sq = v * v;
        return sq;
    endfunction

    // Mostly samples close to the operating point so the levels are crossed often;
    // the rest is full-range noise and the extremes
    function automatic sample_t draw_sample();
        sample_t     s;
        int unsigned kind;
        longint      centre;
        logic [1:0]  mode;
        kind = $urandom_range(0, 19);
        if (kind < 15)
        begin
            s.a = near_square(op_amp);
            s.b = near_square(op_amp);
            s.c = near_square(op_amp);
        end
        else if (kind < 18)
        begin
            s.a = $urandom;
            s.b = $urandom;
            s.c = $urandom;
        end
        else
        begin
            s.a = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            s.b = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            s.c = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        end

        kind = $urandom_range(0, 9);
        mode = active.mode_word[1:0];
        if (kind < 7)
        begin
            // Aim the limit so that the derived trip level sits near the reading
            centre = op_amp;
            if ((mode == MODE_MARGIN || mode == MODE_MARGIN_ALT) && active.margin != 0)
                centre = (longint'(op_amp) * 16384) / active.margin;
            s.mc = clamp16(centre + longint'($urandom_range(0, 1200)) - 600);
        end
        else if (kind < 9)
            s.mc = 16'($urandom);
        else
            s.mc = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        return s;
    endfunction

    function automatic settings_t draw_settings(input int ph, input int unsigned base);
        settings_t  c;
        logic [15:0] swap;
        case ($urandom_range(0, 4))
            0: c.gain = 16'hFFFF;
            1: c.gain = 16'(1 << $urandom_range(10, 15));
            2: c.gain = 16'($urandom);
            3: c.gain = 16'($urandom_range(64, 4096));
            default: c.gain = 16'($urandom_range(16384, 65535));
        endcase
        c.mode_word = {($urandom_range(0, 3) == 0) ? 14'($urandom) : 14'd0,
                       2'($urandom_range(0, 3))};
        c.trip_lvl = clamp16(longint'(base) + longint'($urandom_range(0, 3000)) - 1000);
        c.on_lvl = clamp16(longint'(c.trip_lvl) - longint'($urandom_range(0, 3000)));
        c.off_lvl = clamp16(longint'(c.on_lvl) - longint'($urandom_range(0, 4000)));
        if ($urandom_range(0, 5) == 0)
        begin
            swap = c.on_lvl;
            c.on_lvl = c.off_lvl;
            c.off_lvl = swap;
        end
        c.margin = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                               : 16'($urandom_range(8192, 32768));
        c.on_delta = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 3000));
        c.off_delta = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 4000));

        // A few phases pinned to the register extremes
        if (ph == 1)
            c.gain = 16'h0000;
        if (ph == 2)
            c = {8{16'hFFFF}};
        if (ph == 3)
        begin
            c = '0;
            c.gain = 16'hFFFF;
        end
        return c;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // Drop valid, wait for every pending reading to drain, then load all registers
    task automatic apply_settings(input settings_t c);
        in_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        write_reg(REG_FILTER_GAIN, c.gain);
        write_reg(REG_THRESHOLD_MODE, c.mode_word);
        write_reg(REG_TRIP_THRESHOLD, c.trip_lvl);
        write_reg(REG_ALARM_ON_THRESHOLD, c.on_lvl);
        write_reg(REG_ALARM_OFF_THRESHOLD, c.off_lvl);
        write_reg(REG_CURRENT_MARGIN, c.margin);
        write_reg(REG_ALARM_ON_DELTA, c.on_delta);
        write_reg(REG_ALARM_OFF_DELTA, c.off_delta);
        cfg_we <= 1'b0;
        active = c;
    endtask

    // Offer one sample and return at the edge of its transfer. Between bursts
    // drop valid for a random gap; a zero gap keeps the stream back to back.
    task automatic offer(input sample_t s, input bit typed, input reading_t want);
        int       gap;
        reading_t got;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 48);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        phase_a_squared <= s.a;
        phase_b_squared <= s.b;
        phase_c_squared <= s.c;
        max_current_out <= s.mc;
        do
            @(posedge clk);
        while (!in_ready);
        // The shadow always advances; a hand-written reading replaces the prediction
        got = detector_step(s);
        expected_readings.push_back(typed ? want : got);
    endtask

    // Check every reading transfer against the oldest expectation
    always @(posedge clk)
    begin : reading_check
        reading_t want;
        if (rst_n && out_valid && out_ready)
        begin
            readings_seen++;
            if (expected_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: reading with none expected: rms_high=%0d trip=%0b alarm=%0b",
                             $realtime, rms_high, trip, alarm);
            end
            else
            begin
                want = expected_readings.pop_front();
                if (rms_high !== want.rms || trip !== want.trip || alarm !== want.alarm)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"%0t: reading %0d mismatch: expected rms_high=%0d trip=%0b ",
                                  "alarm=%0b, got rms_high=%0d trip=%0b alarm=%0b"},
                                 $realtime, readings_seen, want.rms, want.trip, want.alarm,
                                 rms_high, trip, alarm);
                end
            end
        end
    end

    // Receiver: stretches of one stall pattern each, plus one long hold-off early
    // in the random part so the block backs up and holds off its input
    initial
    begin : drain
        int style;
        int span;
        int n;
        int hold_left;
        bit held;
        held = 1'b0;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            style = $urandom_range(0, 3);
            span = $urandom_range(16, 256);
            for (n = 0; n < span; n++)
            begin
                @(posedge clk);
                if (!held && readings_seen >= 120)
                begin
                    held = 1'b1;
                    hold_left = 400;
                end
                if (hold_left > 0)
                begin
                    hold_left--;
                    out_ready <= 1'b0;
                end
                else
                    case (style)
                        0: out_ready <= 1'b1;
                        1: out_ready <= 1'($urandom_range(0, 1));
                        2: out_ready <= ((n % 6) < 4);
                        default: out_ready <= ($urandom_range(0, 7) == 0);
                    endcase
            end
        end
    end

    initial
    begin : stimulus
        settings_t   as_reset;
        int unsigned base;
        int          ph;
        int          n;
        as_reset = mk(16'h0000, {14'd0, MODE_STATIC}, 16'hFFFF, 16'hFFFF, 16'h0000,
                      16'd16384, 16'h0000, 16'h0000);
        active = as_reset;

        // Straight out of reset: zero gain keeps the filters at zero, static levels
        add(0, as_reset, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1, {16'd0, 1'b0, 1'b0});
        add(0, as_reset, 32'h0, 32'h0, 32'h0, 16'h0000, 1, {16'd0, 1'b0, 1'b0});
        // Dynamic levels at their limits while the reading is still zero
        add(1, mk(16'h0000, {14'd0, MODE_DYNAMIC}, 16'hFFFF, 16'hFFFF, 16'h0000, 16'd16384,
                  16'h0000, 16'h0000),
            32'h0, 32'h0, 32'h0, 16'h0000, 1, {16'd0, 1'b1, 1'b1});
        add(0, as_reset, 32'h0, 32'h0, 32'h0, 16'hFFFF, 1, {16'd0, 1'b0, 1'b0});
        // Margin product saturates at full scale; upper mode bits are ignored
        add(1, mk(16'h0000, {14'h3FFF, MODE_MARGIN}, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF,
                  16'h0000, 16'h0000),
            32'h0, 32'h0, 32'h0, 16'hFFFF, 1, {16'd0, 1'b0, 1'b0});
        // Spare mode code acts as margin mode; zero margin gives a zero trip level
        add(1, mk(16'h0000, {14'd0, MODE_MARGIN_ALT}, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  16'h0000, 16'h0000),
            32'h0, 32'h0, 32'h0, 16'hFFFF, 1, {16'd0, 1'b1, 1'b1});
        // Deltas larger than the trip level clamp the alarm levels at zero
        add(1, mk(16'h0000, {14'd0, MODE_DYNAMIC}, 16'h0000, 16'h0000, 16'h0000, 16'd16384,
                  16'hFFFF, 16'hFFFF),
            32'h0, 32'h0, 32'h0, 16'd100, 1, {16'd0, 1'b0, 1'b1});

        // Full gain: largest phase wins, filters fall with rounding up, hysteresis
        add(1, mk(16'hFFFF, {14'd0, MODE_STATIC}, 16'd60000, 16'd40000, 16'd20000, 16'd16384,
                  16'h0000, 16'h0000),
            32'hFFFF_FFFF, 32'h0, 32'h0, 16'h0000, 0, '0);
        add(0, as_reset, 32'h0, 32'hFFFF_FFFF, 32'h0, 16'h0000, 0, '0);
        add(0, as_reset, 32'h0, 32'h0, 32'hFFFF_FFFF, 16'h0000, 0, '0);
        add(0, as_reset, 32'd900_000_000, 32'd900_000_000, 32'd900_000_000, 16'h0000, 0, '0);
        add(0, as_reset, 32'd100_000_000, 32'd100_000_000, 32'd100_000_000, 16'h0000, 0, '0);
        add(0, as_reset, 32'd900_000_000, 32'd900_000_000, 32'd900_000_000, 16'h0000, 0, '0);
        add(0, as_reset, 32'd2_025_000_000, 32'd2_025_000_000, 32'd2_025_000_000, 16'h0000, 0, '0);
        add(1, mk(16'hFFFF, {14'd0, MODE_DYNAMIC}, 16'h0000, 16'h0000, 16'h0000, 16'd16384,
                  16'd1000, 16'd2000),
            32'd2_025_000_000, 32'd2_025_000_000, 32'd2_025_000_000, 16'd45000, 0, '0);
        add(0, as_reset, 32'd2_025_000_000, 32'd2_025_000_000, 32'd2_025_000_000, 16'd46500, 0, '0);
        add(1, mk(16'd40000, {14'd0, MODE_MARGIN}, 16'h0000, 16'h0000, 16'h0000, 16'd20000,
                  16'd500, 16'd500),
            32'd2_500_000_000, 32'd2_500_000_000, 32'd2_500_000_000, 16'd40000, 0, '0);
        add(0, as_reset, 32'd1, 32'd1, 32'd1, 16'h0000, 0, '0);
        // Smallest non-zero gain creeps up and back down
        add(1, mk(16'h0001, {14'd0, MODE_STATIC}, 16'hFFFF, 16'hFFFF, 16'h0000, 16'd16384,
                  16'h0000, 16'h0000),
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 0, '0);
        add(0, as_reset, 32'h0, 32'h0, 32'h0, 16'h0000, 0, '0);

        wait (rst_n === 1'b1);
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].reconf)
                apply_settings(script[i].cfg);
            offer(script[i].smp, script[i].typed, script[i].want);
        end

        // Random phases: fresh register set each time, samples wandering around
        // an operating point placed near the levels
        for (ph = 0; ph < PHASES; ph++)
        begin
            base = $urandom_range(0, 65535);
            apply_settings(draw_settings(ph, base));
            op_amp = base;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 24) == 0)
                    op_amp = clamp16(longint'(base) + longint'($urandom_range(0, 5000)) - 2500);
                else
                    op_amp = clamp16(longint'(op_amp) + longint'($urandom_range(0, 300)) - 150);
                offer(draw_sample(), 1'b0, '0);
            end
        end

        // Drain, then allow one item's worth of latency for anything stray
        in_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatches == 0 && expected_readings.size() == 0)
            $display("timed_overcurrent_detector_tb: PASS");
        else
            $display("timed_overcurrent_detector_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
+incdir+hdl
hdl/tod_pkg.sv
hdl/tod_ctrl.sv
hdl/tod_datapath.sv
hdl/timed_overcurrent_detector.sv
tb/timed_overcurrent_detector_tb.sv
